// ===== sv/letter_rule_reachability_checker_macros.svh =====
// ----------------------------------------------------------------------------
// Letter rule reachability checker: assertion macros
// Shared concurrent assertion forms, one for a same-cycle implication and one
// for an implication checked on the following clock edge.
// ----------------------------------------------------------------------------
`ifndef LETTER_RULE_REACHABILITY_CHECKER_MACROS_SVH
`define LETTER_RULE_REACHABILITY_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRRC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrrc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrrc: next-cycle check failed");

`endif

// ===== sv/lrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Letter rule reachability checker package
// Operation codes, field widths and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lrrc_pkg;

  localparam int OP_W     = 2;
  localparam int LETTER_W = 5;

  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_RULE = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPARE  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clear_rules;
    logic rule_read;
    logic rule_write;
    logic search_start;
    logic search_step;
    logic record;
    logic pass_val;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rule_ok;
    logic need_search;
    logic quick_pass;
    logic found;
    logic exhausted;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ===== sv/lrrc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lrrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/lrrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Letter rule reachability checker: controller
// Sequences one request at a time: rule clear, rule update, and the position
// compare with its row-by-row reachability search.
// ----------------------------------------------------------------------------
module lrrc_ctrl import lrrc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] op,
  input  status_t         st,
  output cmd_t            cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RULE_RD,
    ST_RULE_WR,
    ST_CHECK,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (op)
            OP_CLEAR:    cmd.clear_rules = 1'b1;
            OP_ADD_RULE: state_next = ST_RULE_RD;
            OP_COMPARE:  state_next = ST_CHECK;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_RULE_RD: begin
        if (st.rule_ok) begin
          cmd.rule_read = 1'b1;
          state_next    = ST_RULE_WR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RULE_WR: begin
        cmd.rule_write = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_CHECK: begin
        if (st.need_search) begin
          cmd.search_start = 1'b1;
          state_next       = ST_SEARCH;
        end else begin
          cmd.record   = 1'b1;
          cmd.pass_val = st.quick_pass;
          state_next   = ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (st.found || st.exhausted) begin
          cmd.record   = 1'b1;
          cmd.pass_val = st.found;
          state_next   = ST_FINISH;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!st.last || st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lrrc_datapath.sv =====
// ----------------------------------------------------------------------------
// Letter rule reachability checker: datapath
// Rule row memory with per-row valid bits, the reached and expanded sets of
// the search, the pair flag and the verdict output register.
// ----------------------------------------------------------------------------
module lrrc_datapath import lrrc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             st,
  input  logic [LETTER_W-1:0] from_letter,
  input  logic [LETTER_W-1:0] to_letter,
  input  logic                first_present,
  input  logic                second_present,
  input  logic                last_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                verdict
);

  localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  typedef logic [ALPHABET_SIZE-1:0] row_t;

  logic [LETTER_W-1:0] item_a;
  logic [LETTER_W-1:0] item_b;
  logic                item_p1;
  logic                item_p2;
  logic                item_last;

  row_t             valid;
  row_t             reached;
  row_t             expanded;
  logic             inflight;
  logic [IDX_W-1:0] rd_idx;
  logic             pass_q;
  logic             pair_ok;
  logic             verdict_q;
  logic             out_valid_q;

  logic [IDX_W-1:0] idx_a;
  logic [IDX_W-1:0] idx_b;
  row_t             rd_data;
  row_t             row_eff;
  row_t             reached_now;
  row_t             pending;
  row_t             lowest;
  logic [IDX_W-1:0] low_idx;
  logic             exhausted;
  logic             issue;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             out_free;

  assign idx_a = IDX_W'(item_a);
  assign idx_b = IDX_W'(item_b);

  // A row never written since the last clear reads as its identity row.
  assign row_eff     = valid[rd_idx] ? rd_data : (row_t'(1) << rd_idx);
  assign reached_now = reached | (inflight ? row_eff : '0);
  assign pending     = reached_now & ~expanded;
  assign lowest      = pending & (~pending + row_t'(1));
  assign exhausted   = (pending == '0);

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (lowest[i]) begin
        low_idx = low_idx | IDX_W'(i);
      end
    end
  end

  assign issue   = cmd.search_step && !exhausted;
  assign rd_en   = cmd.rule_read || cmd.search_start || issue;
  assign rd_addr = cmd.search_step ? low_idx : idx_a;

  lrrc_ram #(
    .WIDTH (ALPHABET_SIZE),
    .DEPTH (ALPHABET_SIZE)
  ) u_rows (
    .clk     (clk),
    .wr_en   (cmd.rule_write),
    .wr_addr (idx_a),
    .wr_data (row_eff | (row_t'(1) << idx_b)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_q || !out_stall;

  always_comb begin
    st.rule_ok     = (int'(item_a) < ALPHABET_SIZE) && (int'(item_b) < ALPHABET_SIZE);
    st.need_search = item_p1 && item_p2 && (item_a != item_b) && st.rule_ok;
    st.quick_pass  = (item_p1 == item_p2) && (!(item_p1 && item_p2) || (item_a == item_b));
    st.found       = reached_now[idx_b];
    st.exhausted   = exhausted;
    st.last        = item_last;
    st.out_free    = out_free;
  end

  // Item fields and read index carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_a    <= from_letter;
      item_b    <= to_letter;
      item_p1   <= first_present;
      item_p2   <= second_present;
      item_last <= last_position;
    end
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
    if (cmd.record) begin
      pass_q <= cmd.pass_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      reached     <= '0;
      expanded    <= '0;
      inflight    <= 1'b0;
      pair_ok     <= 1'b1;
      out_valid_q <= 1'b0;
      verdict_q   <= 1'b0;
    end else begin
      if (cmd.clear_rules) begin
        valid <= '0;
      end
      if (cmd.rule_write) begin
        valid[idx_a] <= 1'b1;
      end

      if (cmd.search_start) begin
        reached  <= '0;
        expanded <= row_t'(1) << idx_a;
        inflight <= 1'b1;
      end
      if (cmd.search_step) begin
        reached  <= reached_now;
        expanded <= expanded | lowest;
        inflight <= !exhausted;
      end
      if (cmd.record) begin
        reached  <= '0;
        expanded <= '0;
        inflight <= 1'b0;
      end

      if (cmd.finish && item_last) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall) begin
        out_valid_q <= 1'b0;
      end
      if (cmd.finish) begin
        if (item_last) begin
          verdict_q <= pair_ok & pass_q;
          pair_ok   <= 1'b1;
        end else begin
          pair_ok <= pair_ok & pass_q;
        end
      end
    end
  end

  assign out_valid = out_valid_q;
  assign verdict   = verdict_q;

endmodule

// ===== sv/letter_rule_reachability_checker.sv =====
// ----------------------------------------------------------------------------
// Letter rule reachability checker
// Holds a matrix of directed letter rules and checks, position by position,
// whether a second word can be derived from a first through chains of rules.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in_ channel (in_valid / in_stall) carrying op,
// two letters and the position flags. A clear request (op 0) takes effect in
// the cycle it is accepted, and the next request can be taken in the cycle after.
// An add-rule request (op 1) reads and then rewrites one rule row; it is dropped
// without a read when either letter lies outside the alphabet. A compare
// request (op 2) goes from its check state straight to its finish state when no
// search is needed; otherwise the search expands rule rows one per cycle from the
// rule memory's read port until the target letter is reached or none is left.
// Only a compare request with last_position set produces a verdict on the out_
// channel (out_valid / out_stall), registered when its finish state ends. The verdict
// sits in an output register: the block takes further requests while it waits,
// and only a later verdict has to wait until the receiver takes the earlier one.
// Reset is synchronous on rst: the rule matrix returns to identity at once
// through per-row valid bits, the pair flag is set and the output is emptied.
// A stalled verdict holds its value until accepted.
// ----------------------------------------------------------------------------
`include "letter_rule_reachability_checker_macros.svh"

module letter_rule_reachability_checker import lrrc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [LETTER_W-1:0] from_letter,
  input  logic [LETTER_W-1:0] to_letter,
  input  logic                first_present,
  input  logic                second_present,
  input  logic                last_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                verdict
);

  cmd_t    cmd;
  status_t st;

  // The controller owns sequencing and the input handshake.
  lrrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath owns the rule memory, the search sets and the verdict.
  lrrc_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .from_letter    (from_letter),
    .to_letter      (to_letter),
    .first_present  (first_present),
    .second_present (second_present),
    .last_position  (last_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .verdict        (verdict)
  );

  // An accepted compare always keeps the block busy in the next cycle.
  `LRRC_ASSERT_NEXT(a_compare_busy, clk, rst, in_valid && !in_stall && op == OP_COMPARE, in_stall)
  // A verdict is only written into a free output register.
  `LRRC_ASSERT_SAME(a_verdict_slot_free, clk, rst, cmd.finish && st.last, st.out_free)
  // A rule row is only rewritten straight after it has been read.
  `LRRC_ASSERT_SAME(a_write_after_read, clk, rst, cmd.rule_write, $past(cmd.rule_read))
  // The output never becomes valid without a finishing last position.
  `LRRC_ASSERT_NEXT(a_verdict_source, clk, rst, !out_valid && !(cmd.finish && st.last), !out_valid)

endmodule
